FILE: rtl/core/imu_angle_frame_parser_assert.svh
// Assertion macros shared by the angle frame parser modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef IMU_ANGLE_FRAME_PARSER_ASSERT_SVH
`define IMU_ANGLE_FRAME_PARSER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define IAFP_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("iafp assertion failed");

// The condition must hold in the cycle after the trigger.
`define IAFP_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("iafp assertion failed");

`endif

FILE: rtl/core/iafp_pkg.sv
`timescale 1ns / 1ps

package iafp_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'h55;
    localparam logic [7:0] KIND_BYTE   = 8'h53;
    localparam int         IDX_W       = 4;
    localparam logic [IDX_W-1:0] SUM_BYTES   = 4'd8;
    localparam logic [IDX_W-1:0] STORE_BYTES = 4'd6;
    localparam logic [IDX_W-1:0] LAST_INDEX  = 4'd8;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_angle_item;

    typedef struct packed {
        logic        hit;
        t_angle_item angles;
    } t_step_result;

endpackage

FILE: rtl/core/iafp_rx_if.sv
`timescale 1ns / 1ps

interface iafp_rx_if;
    import iafp_pkg::*;

    logic     valid;
    logic     ready;
    t_rx_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/iafp_angle_if.sv
`timescale 1ns / 1ps

interface iafp_angle_if;
    import iafp_pkg::*;

    logic        valid;
    logic        ready;
    t_angle_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/imu_angle_frame_parser.sv
// Angle frame parser for an inertial sensor serial stream. Feed one received
// byte per item on i_rx. The block hunts for the header 0x55 0x53, collects
// nine payload bytes, and checks the last one against the low eight bits of
// the sum of the header and the first eight payload bytes. A good frame yields
// one item on o_angles carrying roll, pitch and yaw as signed little-endian
// 16-bit raw values; a bad frame yields nothing. One byte can be taken every
// clock cycle, unless the output stalls. The last byte of a frame sits in the
// input register while the parse step runs, and that step loads the result
// into the output register. A stalled output holds up the input only once
// both registers are full.
`timescale 1ns / 1ps
`include "imu_angle_frame_parser_assert.svh"

module imu_angle_frame_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    iafp_rx_if.sink             i_rx,
    iafp_angle_if.source        o_angles
);
    import iafp_pkg::*;

    // Input register: holds one byte until the parse step can take it.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Output register: holds one finished result until the sink takes it.
    logic        r_out_valid;
    t_angle_item r_out_data;

    logic         in_accept;
    logic         step_go;
    t_step_result step_res;

    // The parse step may run whenever the output register is free or is
    // being emptied in this cycle, because a step can produce a result.
    assign step_go   = r_in_valid && (!r_out_valid || o_angles.ready);
    assign i_rx.ready = !r_in_valid || step_go;
    assign in_accept = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx.payload.rx_byte;
        end
    end

    iafp_parser_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_go),
        .i_byte   (r_in_byte),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_res.hit) begin
            r_out_valid <= 1'b1;
        end else if (o_angles.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_res.hit) begin
            r_out_data <= step_res.angles;
        end
    end

    assign o_angles.valid   = r_out_valid;
    assign o_angles.payload = r_out_data;

    `IAFP_ASSERT_NEXT(a_in_captured, in_accept, r_in_valid)
    `IAFP_ASSERT_NEXT(a_hit_loads_out, step_res.hit, r_out_valid && r_out_data == $past(step_res.angles))
    `IAFP_ASSERT_NOW(a_no_overwrite, step_res.hit, !r_out_valid || o_angles.ready)

endmodule

FILE: rtl/core/iafp_parser_core.sv
`timescale 1ns / 1ps
`include "imu_angle_frame_parser_assert.svh"

module iafp_parser_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output iafp_pkg::t_step_result o_result
);
    import iafp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_angle [STORE_BYTES];
    logic             store_en;
    logic             hit;

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_sum    = r_sum;
        store_en = 1'b0;
        hit      = 1'b0;
        unique case (r_phase)
            PH_WAIT: begin
                if (i_byte == KIND_BYTE) begin
                    n_sum   = r_sum + i_byte;
                    n_idx   = '0;
                    n_phase = PH_PAYLOAD;
                end else if (i_byte == SYNC_BYTE) begin
                    n_phase = PH_WAIT;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                if (r_idx < SUM_BYTES) begin
                    n_sum = r_sum + i_byte;
                end
                store_en = (r_idx < STORE_BYTES);
                if (r_idx >= SUM_BYTES) begin
                    hit     = (r_sum == i_byte);
                    n_phase = PH_HUNT;
                end
                n_idx = r_idx + 1'b1;
            end
            default: begin
                // Hunting; the unused phase code behaves the same way.
                if (i_byte == SYNC_BYTE) begin
                    n_sum   = i_byte;
                    n_phase = PH_WAIT;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_en) begin
            r_angle[r_idx[2:0]] <= i_byte;
        end
    end

    always_comb begin
        o_result.hit          = i_step && hit;
        o_result.angles.roll  = {r_angle[1], r_angle[0]};
        o_result.angles.pitch = {r_angle[3], r_angle[2]};
        o_result.angles.yaw   = {r_angle[5], r_angle[4]};
    end

    `IAFP_ASSERT_NEXT(a_header_done, i_step && r_phase == PH_WAIT && i_byte == KIND_BYTE, r_phase == PH_PAYLOAD && r_idx == '0 && r_sum == (SYNC_BYTE + KIND_BYTE))
    `IAFP_ASSERT_NOW(a_index_bound, r_phase == PH_PAYLOAD, r_idx <= LAST_INDEX)
    `IAFP_ASSERT_NEXT(a_hunt_no_payload, i_step && r_phase == PH_HUNT, r_phase != PH_PAYLOAD)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Checks the angle frame parser with a byte stream made of good frames, frames
// with a bad checksum, broken headers, repeated sync bytes and loose noise.
// A driver feeds bytes from a queue, and a monitor predicts every accepted byte
// and compares each result item on the output with the oldest expected one.
module tb_top;
    import iafp_pkg::*;

    // Parser phases, kept here for the prediction only.
    typedef enum logic [1:0] {
        HUNT_SYNC,
        WAIT_KIND,
        TAKE_PAYLOAD
    } t_parse_phase;

    // One byte waiting to be sent. A byte marked drain_first is held back until
    // every expected result has come out. Calm bytes are sent with no idling on
    // either side.
    typedef struct {
        logic [7:0] value;
        bit         drain_first;
        bit         calm;
    } t_feed_byte;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    iafp_rx_if    rx_if();
    iafp_angle_if ang_if();

    imu_angle_frame_parser DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_rx     (rx_if.sink),
        .o_angles (ang_if.source)
    );

    t_feed_byte  byte_feed_q[$];
    t_angle_item angle_expect_q[$];
    int          err_count = 0;

    // Predicted parser state.
    t_parse_phase pred_phase = HUNT_SYNC;
    logic [3:0]   pred_index = '0;
    logic [7:0]   pred_sum = '0;
    logic [7:0]   pred_store[6];

    // Idling control for both sides.
    int  tx_gap_left = 0;
    int  rx_stall_left = 0;
    logic calm_now = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    // The interface inputs get known values at time zero; reset is released
    // once and never asserted again.
    initial begin
        rx_if.valid = 1'b0;
        rx_if.payload = '0;
        ang_if.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Advances the predicted parser by one accepted byte and queues the angle
    // item when a frame with a good checksum ends.
    task automatic advance_parse(input logic [7:0] b);
        t_angle_item angles;
        case (pred_phase)
            WAIT_KIND: begin
                if (b == KIND_BYTE) begin
                    pred_sum = pred_sum + b;
                    pred_index = '0;
                    pred_phase = TAKE_PAYLOAD;
                end else if (b != SYNC_BYTE) begin
                    // A repeated sync byte keeps waiting, anything else is a
                    // broken header.
                    pred_phase = HUNT_SYNC;
                end
            end
            TAKE_PAYLOAD: begin
                if (pred_index < SUM_BYTES) begin
                    pred_sum = pred_sum + b;
                end
                if (pred_index < STORE_BYTES) begin
                    pred_store[pred_index] = b;
                end
                if (pred_index >= SUM_BYTES) begin
                    if (pred_sum == b) begin
                        angles.roll  = {pred_store[1], pred_store[0]};
                        angles.pitch = {pred_store[3], pred_store[2]};
                        angles.yaw   = {pred_store[5], pred_store[4]};
                        angle_expect_q.push_back(angles);
                    end
                    pred_phase = HUNT_SYNC;
                end
                pred_index = pred_index + 4'd1;
            end
            default: begin
                if (b == SYNC_BYTE) begin
                    pred_sum = b;
                    pred_phase = WAIT_KIND;
                end else begin
                    pred_phase = HUNT_SYNC;
                end
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b, input bit drain_first, input bit calm);
        t_feed_byte fb;
        fb.value = b;
        fb.drain_first = drain_first;
        fb.calm = calm;
        byte_feed_q.push_back(fb);
    endtask

    // Queues a whole frame. The two spare payload bytes are random, and
    // bad_sum flips the checksum byte so the frame must be dropped.
    task automatic queue_frame(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw, input bit bad_sum,
                               input bit drain_first, input bit calm);
        logic [7:0] body[8];
        logic [7:0] sum;
        body = '{roll[7:0], roll[15:8], pitch[7:0], pitch[15:8],
                 yaw[7:0], yaw[15:8], 8'($urandom), 8'($urandom)};
        sum = SYNC_BYTE + KIND_BYTE;
        queue_byte(SYNC_BYTE, drain_first, calm);
        queue_byte(KIND_BYTE, 1'b0, calm);
        foreach (body[k]) begin
            sum = sum + body[k];
            queue_byte(body[k], 1'b0, calm);
        end
        if (bad_sum) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        queue_byte(sum, 1'b0, calm);
    endtask

    function automatic logic [15:0] pick_angle();
        // Mostly random raw values, now and then one of the extremes.
        case ($urandom_range(0, 11))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Fills the byte queue: a short directed part, then random frames and noise.
    initial begin
        int  kind;
        bit  calm;
        int  drain_at;

        // Good frame with the largest, smallest and minus-one raw values.
        queue_frame(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        // Repeated sync byte, then a frame of zeros with a corrupted checksum.
        queue_byte(SYNC_BYTE, 1'b0, 1'b0);
        queue_frame(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        // Broken header.
        queue_byte(SYNC_BYTE, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);

        drain_at = 250;
        while (byte_feed_q.size() < 575) begin
            // Some stretches run with no idling, and so does the whole tail.
            calm = (byte_feed_q.size() > 500) || ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
                queue_frame(pick_angle(), pick_angle(), pick_angle(), 1'b0,
                            byte_feed_q.size() >= drain_at, calm);
                if (byte_feed_q.size() > drain_at) begin
                    drain_at = 1000000;
                end
            end else if (kind < 15) begin
                queue_frame(pick_angle(), pick_angle(), pick_angle(), 1'b1, 1'b0, calm);
            end else if (kind < 17) begin
                repeat ($urandom_range(1, 6)) queue_byte(8'($urandom), 1'b0, calm);
            end else if (kind < 18) begin
                queue_byte(SYNC_BYTE, 1'b0, calm);
                queue_byte(8'($urandom_range(0, 255)) | 8'h80, 1'b0, calm);
            end else begin
                repeat ($urandom_range(1, 3)) queue_byte(SYNC_BYTE, 1'b0, calm);
                queue_frame(pick_angle(), pick_angle(), pick_angle(), 1'b0, 1'b0, calm);
            end
        end
    end

    // Byte driver. A new byte is chosen only when the channel is free: either
    // nothing is offered or the offered byte is taken at this edge.
    always @(posedge clk) begin
        t_feed_byte fb;
        if (!rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_if.ready) begin
            if (tx_gap_left != 0) begin
                tx_gap_left--;
                rx_if.valid <= 1'b0;
            end else if (byte_feed_q.size() == 0) begin
                rx_if.valid <= 1'b0;
            end else if (byte_feed_q[0].drain_first &&
                         (rx_if.valid || angle_expect_q.size() != 0)) begin
                // Hold off until every result already predicted has come out.
                rx_if.valid <= 1'b0;
            end else if (!byte_feed_q[0].calm && $urandom_range(0, 7) == 0) begin
                tx_gap_left = $urandom_range(1, 19) - 1;
                rx_if.valid <= 1'b0;
            end else begin
                fb = byte_feed_q.pop_front();
                rx_if.valid <= 1'b1;
                rx_if.payload <= t_rx_item'(fb.value);
                calm_now <= fb.calm;
            end
        end
    end

    // The result side stalls in random bursts except in calm stretches.
    always @(posedge clk) begin
        if (!rst_n) begin
            ang_if.ready <= 1'b0;
        end else if (calm_now) begin
            rx_stall_left = 0;
            ang_if.ready <= 1'b1;
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
            ang_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(1, 19) - 1;
            ang_if.ready <= 1'b0;
        end else begin
            ang_if.ready <= 1'b1;
        end
    end

    // Monitor. Results are checked before the byte taken at the same edge is
    // predicted; a byte cannot produce a result in the cycle it is taken.
    always @(posedge clk) begin
        t_angle_item want;
        t_angle_item got;
        if (rst_n) begin
            if (ang_if.valid && ang_if.ready) begin
                got = ang_if.payload;
                if (angle_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result roll %0d pitch %0d yaw %0d",
                                              got.roll, got.pitch, got.yaw));
                end else begin
                    want = angle_expect_q.pop_front();
                    if (got.roll !== want.roll) begin
                        report_mismatch($sformatf("roll got %0d want %0d",
                                                  got.roll, want.roll));
                    end
                    if (got.pitch !== want.pitch) begin
                        report_mismatch($sformatf("pitch got %0d want %0d",
                                                  got.pitch, want.pitch));
                    end
                    if (got.yaw !== want.yaw) begin
                        report_mismatch($sformatf("yaw got %0d want %0d",
                                                  got.yaw, want.yaw));
                    end
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                advance_parse(rx_if.payload.rx_byte);
            end
        end
    end

    // End of run: all bytes taken, all results in, then a quiet stretch so
    // that a stray late result would still be caught.
    initial begin
        @(posedge rst_n);
        while (byte_feed_q.size() != 0 || rx_if.valid) @(posedge clk);
        while (angle_expect_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
